>>> rtl/maze_all_paths_dfs_core_macros.svh
// assertion macros used by the checker
`ifndef MAZE_ALL_PATHS_DFS_CORE_MACROS_SVH
`define MAZE_ALL_PATHS_DFS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MAZEDFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MAZEDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mazedfs_pkg.sv
package mazedfs_pkg;

  localparam int GRID_ROWS   = 16;
  localparam int GRID_COLS   = 16;
  localparam int STACK_DEPTH = 256;

  localparam int CELLS   = GRID_ROWS * GRID_COLS;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int SIDX_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int COORD_W = 4;
  localparam int DIR_W   = 3;

  // item kinds
  localparam logic [1:0] K_LOAD    = 2'd0;
  localparam logic [1:0] K_STEP    = 2'd1;
  localparam logic [1:0] K_READ    = 2'd2;
  localparam logic [1:0] K_RESTART = 2'd3;

  // result events
  localparam logic [2:0] EV_LOADED    = 3'd0;
  localparam logic [2:0] EV_PUSHED    = 3'd1;
  localparam logic [2:0] EV_POPPED    = 3'd2;
  localparam logic [2:0] EV_FINISHED  = 3'd3;
  localparam logic [2:0] EV_READ      = 3'd4;
  localparam logic [2:0] EV_RESTARTED = 3'd5;

  // search directions, tried in this order
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_START_ROW = 3'd0;
  localparam logic [2:0] CFG_START_COL = 3'd1;
  localparam logic [2:0] CFG_EXIT_ROW  = 3'd2;
  localparam logic [2:0] CFG_EXIT_COL  = 3'd3;

  typedef struct packed {
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic              wr_wall;
    logic              wr_mark;
    logic              clr_marks;
  } cell_req_t;

  typedef struct packed {
    logic wall;
    logic mark;
  } cell_rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   dir;
  } stk_entry_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } nbr_t;

  function automatic logic in_grid(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    return (32'(r) < GRID_ROWS) && (32'(c) < GRID_COLS);
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return CELL_W'(32'(r) * GRID_COLS + 32'(c));
  endfunction

  function automatic nbr_t step_nbr(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                    input logic [DIR_W-1:0] d);
    nbr_t             n;
    logic [COORD_W:0] r5;
    logic [COORD_W:0] c5;
    r5 = {1'b0, r};
    c5 = {1'b0, c};
    n.ok = 1'b0;
    unique case (d)
      DIR_RIGHT: begin
        c5 = c5 + 1'b1;
        n.ok = (32'(c5) < GRID_COLS);
      end
      DIR_DOWN: begin
        r5 = r5 + 1'b1;
        n.ok = (32'(r5) < GRID_ROWS);
      end
      DIR_LEFT: begin
        n.ok = (c != '0);
        c5 = c5 - 1'b1;
      end
      DIR_UP: begin
        n.ok = (r != '0);
        r5 = r5 - 1'b1;
      end
      default: n.ok = 1'b0;
    endcase
    n.ok  = n.ok && (32'(r5) < GRID_ROWS) && (32'(c5) < GRID_COLS);
    n.row = r5[COORD_W-1:0];
    n.col = c5[COORD_W-1:0];
    return n;
  endfunction

endpackage

>>> rtl/mazedfs_ram.sv
module mazedfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mazedfs_cell_map.sv
module mazedfs_cell_map
  import mazedfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_req_t req,
  output cell_rsp_t rsp,
  output logic      clearing
);

  logic              clr_r;
  logic              clr_keep_r;
  logic [CELL_W:0]   clr_idx_r;
  logic              clr_last;
  logic              ram_we;
  logic              ram_re;
  logic [CELL_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_raddr;
  logic [1:0]        ram_wdata;
  logic [1:0]        rdata;

  // bit 1 wall, bit 0 on-path mark
  mazedfs_ram #(
    .WIDTH(2),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign clr_last = (32'(clr_idx_r) == CELLS);

  // sweep reads entry k while writing back entry k-1; walls kept on a restart,
  // everything zeroed after reset
  always_comb begin
    if (clr_r) begin
      ram_re    = !clr_last;
      ram_raddr = clr_idx_r[CELL_W-1:0];
      ram_we    = (clr_idx_r != '0);
      ram_waddr = CELL_W'(clr_idx_r - 1'b1);
      ram_wdata = {clr_keep_r & rdata[1], 1'b0};
    end else begin
      ram_re    = req.rd_en;
      ram_raddr = req.rd_addr;
      ram_we    = req.wr_en;
      ram_waddr = req.wr_addr;
      ram_wdata = {req.wr_wall, req.wr_mark};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_keep_r <= 1'b0;
      clr_idx_r  <= '0;
    end else if (clr_r) begin
      if (clr_last) begin
        clr_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end else if (req.clr_marks) begin
      clr_r      <= 1'b1;
      clr_keep_r <= 1'b1;
      clr_idx_r  <= '0;
    end
  end

  assign clearing = clr_r;
  assign rsp.wall = rdata[1];
  assign rsp.mark = rdata[0];

endmodule

>>> rtl/maze_all_paths_dfs_core.sv
// channel   direction  transaction when            payload
// input     in         start & !busy               in_kind, in_row, in_col, in_wall,
//                                                  in_entry_index
// result    out        out_valid (one cycle)       out_event_res .. out_entry_valid
// config    in         cfg_valid & cfg_ready       cfg_index, cfg_wdata
//
// every item gives one result, registered, in the cycle after the item finishes.
// a load or read answers at once or after one cell map or stack read; a search step reads the
// stack, then tries neighbours in turn on the single cell map read port, then writes back.
// a restart answers at once, then a sweep clears the path marks, busy high.
// rst_n is synchronous; after its release the same sweep clears the whole cell map
// with busy high. the receiver cannot stall.
module maze_all_paths_dfs_core
  import mazedfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic        in_wall,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  output logic [2:0]  out_event_res,
  output logic [3:0]  out_cell_row,
  output logic [3:0]  out_cell_col,
  output logic [8:0]  out_depth,
  output logic        out_at_exit,
  output logic [15:0] out_path_count,
  output logic        out_found_any,
  output logic        out_entry_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOAD_WR  = 4'd1;
  localparam logic [3:0] S_START_WR = 4'd2;
  localparam logic [3:0] S_TOP      = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_PUSH_WR  = 4'd6;
  localparam logic [3:0] S_POP_WR   = 4'd7;
  localparam logic [3:0] S_READ_OUT = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [3:0]         start_row_r, start_col_r, exit_row_r, exit_col_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [15:0]        paths_r, paths_nxt;
  logic               found_r, found_nxt;
  logic               done_r, done_nxt;

  logic [COORD_W-1:0] ld_row_r, ld_col_r;
  logic               ld_wall_r;
  logic [COORD_W-1:0] top_row_r, top_row_nxt, top_col_r, top_col_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;
  logic [COORD_W-1:0] nbr_row_r, nbr_row_nxt, nbr_col_r, nbr_col_nxt;

  logic               out_valid_r;
  logic [2:0]         out_event_r;
  logic [3:0]         out_row_r, out_col_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_exit_r, out_entry_r, out_found_r;
  logic [15:0]        out_paths_r;

  logic               emit;
  logic [2:0]         res_event_nxt;
  logic [3:0]         res_row_nxt, res_col_nxt;
  logic               res_exit_nxt, res_entry_nxt;

  cell_req_t          cell_req;
  cell_rsp_t          cell_rsp;
  logic               map_clearing;

  logic               stk_we, stk_re;
  logic [SIDX_W-1:0]  stk_waddr, stk_raddr, top_idx;
  stk_entry_t         stk_wdata, stk_rdata;

  logic [COORD_W-1:0] push_row, push_col;
  logic               push_hit;
  logic               accept;
  logic               stack_full;
  nbr_t               nbr;

  mazedfs_cell_map u_cell_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cell_req),
    .rsp     (cell_rsp),
    .clearing(map_clearing)
  );

  mazedfs_ram #(
    .WIDTH($bits(stk_entry_t)),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign busy       = (state_r != S_IDLE) || map_clearing;
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign top_idx    = SIDX_W'(depth_r - 1'b1);
  assign stack_full = (32'(depth_r) == STACK_DEPTH);
  assign nbr        = step_nbr(top_row_r, top_col_r, dir_r);
  assign push_row   = (state_r == S_START_WR) ? start_row_r : nbr_row_r;
  assign push_col   = (state_r == S_START_WR) ? start_col_r : nbr_col_r;
  assign push_hit   = (push_row == exit_row_r) && (push_col == exit_col_r);

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    paths_nxt     = paths_r;
    found_nxt     = found_r;
    done_nxt      = done_r;
    top_row_nxt   = top_row_r;
    top_col_nxt   = top_col_r;
    dir_nxt       = dir_r;
    nbr_row_nxt   = nbr_row_r;
    nbr_col_nxt   = nbr_col_r;
    emit          = 1'b0;
    res_event_nxt = EV_LOADED;
    res_row_nxt   = '0;
    res_col_nxt   = '0;
    res_exit_nxt  = 1'b0;
    res_entry_nxt = 1'b0;
    cell_req      = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            K_LOAD: begin
              if (in_grid(in_row, in_col)) begin
                cell_req.rd_en   = 1'b1;
                cell_req.rd_addr = cell_addr(in_row, in_col);
                state_nxt        = S_LOAD_WR;
              end else begin
                emit          = 1'b1;
                res_event_nxt = EV_LOADED;
              end
            end
            K_STEP: begin
              if (done_r) begin
                emit          = 1'b1;
                res_event_nxt = EV_FINISHED;
              end else if (depth_r == '0) begin
                if (!in_grid(start_row_r, start_col_r)) begin
                  done_nxt      = 1'b1;
                  emit          = 1'b1;
                  res_event_nxt = EV_FINISHED;
                end else begin
                  cell_req.rd_en   = 1'b1;
                  cell_req.rd_addr = cell_addr(start_row_r, start_col_r);
                  state_nxt        = S_START_WR;
                end
              end else begin
                stk_re    = 1'b1;
                stk_raddr = top_idx;
                state_nxt = S_TOP;
              end
            end
            K_READ: begin
              if (32'(in_entry_index) < 32'(depth_r)) begin
                stk_re    = 1'b1;
                stk_raddr = SIDX_W'(in_entry_index);
                state_nxt = S_READ_OUT;
              end else begin
                emit          = 1'b1;
                res_event_nxt = EV_READ;
              end
            end
            K_RESTART: begin
              cell_req.clr_marks = 1'b1;
              depth_nxt          = '0;
              paths_nxt          = '0;
              found_nxt          = 1'b0;
              done_nxt           = 1'b0;
              emit               = 1'b1;
              res_event_nxt      = EV_RESTARTED;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_LOAD_WR: begin
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = cell_addr(ld_row_r, ld_col_r);
        cell_req.wr_wall = ld_wall_r;
        cell_req.wr_mark = cell_rsp.mark;
        emit             = 1'b1;
        res_event_nxt    = EV_LOADED;
        state_nxt        = S_IDLE;
      end

      S_START_WR: begin
        // start cell goes on even when it is a wall
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = cell_addr(start_row_r, start_col_r);
        cell_req.wr_wall = cell_rsp.wall;
        cell_req.wr_mark = 1'b1;
        stk_we           = 1'b1;
        stk_waddr        = '0;
        stk_wdata        = '{row: start_row_r, col: start_col_r, dir: DIR_RIGHT};
        depth_nxt        = DEPTH_W'(1);
        emit             = 1'b1;
        res_event_nxt    = EV_PUSHED;
        res_row_nxt      = start_row_r;
        res_col_nxt      = start_col_r;
        if (push_hit) begin
          res_exit_nxt = 1'b1;
          found_nxt    = 1'b1;
          if (paths_r != '1) begin
            paths_nxt = paths_r + 16'd1;
          end
        end
        state_nxt = S_IDLE;
      end

      S_TOP: begin
        top_row_nxt = stk_rdata.row;
        top_col_nxt = stk_rdata.col;
        dir_nxt     = stk_rdata.dir;
        if (stack_full) begin
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = cell_addr(stk_rdata.row, stk_rdata.col);
          state_nxt        = S_POP_WR;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (dir_r >= DIR_NONE) begin
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = cell_addr(top_row_r, top_col_r);
          state_nxt        = S_POP_WR;
        end else if (nbr.ok) begin
          cell_req.rd_en   = 1'b1;
          cell_req.rd_addr = cell_addr(nbr.row, nbr.col);
          nbr_row_nxt      = nbr.row;
          nbr_col_nxt      = nbr.col;
          state_nxt        = S_CHECK;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end

      S_CHECK: begin
        if (!cell_rsp.wall && !cell_rsp.mark) begin
          cell_req.wr_en   = 1'b1;
          cell_req.wr_addr = cell_addr(nbr_row_r, nbr_col_r);
          cell_req.wr_wall = cell_rsp.wall;
          cell_req.wr_mark = 1'b1;
          // top frame resumes after this direction next time
          stk_we           = 1'b1;
          stk_waddr        = top_idx;
          stk_wdata        = '{row: top_row_r, col: top_col_r, dir: dir_r + 1'b1};
          state_nxt        = S_PUSH_WR;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end

      S_PUSH_WR: begin
        stk_we        = 1'b1;
        stk_waddr     = SIDX_W'(depth_r);
        stk_wdata     = '{row: nbr_row_r, col: nbr_col_r, dir: DIR_RIGHT};
        depth_nxt     = depth_r + 1'b1;
        emit          = 1'b1;
        res_event_nxt = EV_PUSHED;
        res_row_nxt   = nbr_row_r;
        res_col_nxt   = nbr_col_r;
        if (push_hit) begin
          res_exit_nxt = 1'b1;
          found_nxt    = 1'b1;
          if (paths_r != '1) begin
            paths_nxt = paths_r + 16'd1;
          end
        end
        state_nxt = S_IDLE;
      end

      S_POP_WR: begin
        cell_req.wr_en   = 1'b1;
        cell_req.wr_addr = cell_addr(top_row_r, top_col_r);
        cell_req.wr_wall = cell_rsp.wall;
        cell_req.wr_mark = 1'b0;
        depth_nxt        = depth_r - 1'b1;
        if (depth_r == DEPTH_W'(1)) begin
          done_nxt = 1'b1;
        end
        emit          = 1'b1;
        res_event_nxt = EV_POPPED;
        res_row_nxt   = top_row_r;
        res_col_nxt   = top_col_r;
        state_nxt     = S_IDLE;
      end

      S_READ_OUT: begin
        emit          = 1'b1;
        res_event_nxt = EV_READ;
        res_row_nxt   = stk_rdata.row;
        res_col_nxt   = stk_rdata.col;
        res_entry_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      paths_r     <= '0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      paths_r     <= paths_nxt;
      found_r     <= found_nxt;
      done_r      <= done_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r <= 4'd1;
      start_col_r <= 4'd1;
      exit_row_r  <= 4'd7;
      exit_col_r  <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_ROW: start_row_r <= cfg_wdata;
        CFG_START_COL: start_col_r <= cfg_wdata;
        CFG_EXIT_ROW:  exit_row_r  <= cfg_wdata;
        CFG_EXIT_COL:  exit_col_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_row_r  <= in_row;
      ld_col_r  <= in_col;
      ld_wall_r <= in_wall;
    end
    top_row_r <= top_row_nxt;
    top_col_r <= top_col_nxt;
    dir_r     <= dir_nxt;
    nbr_row_r <= nbr_row_nxt;
    nbr_col_r <= nbr_col_nxt;
    if (emit) begin
      out_event_r <= res_event_nxt;
      out_row_r   <= res_row_nxt;
      out_col_r   <= res_col_nxt;
      out_exit_r  <= res_exit_nxt;
      out_entry_r <= res_entry_nxt;
      out_depth_r <= depth_nxt;
      out_paths_r <= paths_nxt;
      out_found_r <= found_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_col    = out_col_r;
  assign out_depth       = 9'(out_depth_r);
  assign out_at_exit     = out_exit_r;
  assign out_path_count  = out_paths_r;
  assign out_found_any   = out_found_r;
  assign out_entry_valid = out_entry_r;

endmodule

>>> rtl/mazedfs_chk.sv
`include "maze_all_paths_dfs_core_macros.svh"

module mazedfs_chk
  import mazedfs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic [2:0]  out_event_res,
  input logic [8:0]  out_depth,
  input logic        out_at_exit,
  input logic [15:0] out_path_count,
  input logic        out_found_any,
  input logic        out_entry_valid
);

  // a restart answers at once with everything cleared
  `MAZEDFS_ASSERT_NEXT(a_restart_clears, clk, rst_n,
    start && !busy && (in_kind == K_RESTART),
    out_valid && (out_event_res == EV_RESTARTED) && (out_depth == '0) &&
    (out_path_count == '0) && !out_found_any,
    "restart transaction did not clear the search")

  // reaching the exit is only reported on a push and sets the found flag
  `MAZEDFS_ASSERT_SAME(a_exit_on_push, clk, rst_n,
    out_valid && out_at_exit,
    (out_event_res == EV_PUSHED) && out_found_any && (out_path_count != '0) &&
    (out_depth != '0),
    "exit reported outside a push")

  // a valid stack entry only comes with an entry read
  `MAZEDFS_ASSERT_SAME(a_entry_on_read, clk, rst_n,
    out_valid && out_entry_valid,
    (out_event_res == EV_READ) && (out_depth != '0),
    "entry valid outside an entry read")

  // no result out of an idle block with no transaction
  `MAZEDFS_ASSERT_NEXT(a_no_spurious_result, clk, rst_n,
    !busy && !start,
    !out_valid,
    "result without a transaction")

endmodule

bind maze_all_paths_dfs_core mazedfs_chk u_mazedfs_chk (.*);

>>> sim/tb_maze_all_paths_dfs_core.sv
`timescale 1ns / 1ps

module tb_maze_all_paths_dfs_core;
  import mazedfs_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int ITEM_TARGET   = 1250;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int SEARCH_BUDGET = 300;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [8:0]  depth;
    logic        at_exit;
    logic [15:0] count;
    logic        found;
    logic        entry_ok;
  } maze_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = K_LOAD;
  logic [3:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  logic        in_wall = 1'b0;
  logic [7:0]  in_entry_index = '0;
  logic        out_valid;
  logic [2:0]  out_event_res;
  logic [3:0]  out_cell_row;
  logic [3:0]  out_cell_col;
  logic [8:0]  out_depth;
  logic        out_at_exit;
  logic [15:0] out_path_count;
  logic        out_found_any;
  logic        out_entry_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_START_ROW;
  logic [3:0]  cfg_wdata = '0;

  maze_all_paths_dfs_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_wall         (in_wall),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_event_res   (out_event_res),
    .out_cell_row    (out_cell_row),
    .out_cell_col    (out_cell_col),
    .out_depth       (out_depth),
    .out_at_exit     (out_at_exit),
    .out_path_count  (out_path_count),
    .out_found_any   (out_found_any),
    .out_entry_valid (out_entry_valid),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // maze state as the block should hold it
  bit               wall_map [CELLS];
  bit               on_path  [CELLS];
  logic [3:0]       stk_row  [STACK_DEPTH];
  logic [3:0]       stk_col  [STACK_DEPTH];
  logic [DIR_W-1:0] stk_dir  [STACK_DEPTH];
  int               path_depth;
  int               path_total;
  bit               found_flag;
  bit               search_over;
  logic [3:0]       start_r, start_c, exit_r, exit_c;

  maze_result_t pending_results[$];

  int items_sent = 0;
  int n_pushes = 0;
  int n_pops = 0;
  int n_exits = 0;
  int n_reads = 0;
  int n_loads = 0;
  int n_cfg = 0;
  int fail_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int quiet_cycles = 0;

  function automatic bit on_grid(int r, int c);
    return r >= 0 && c >= 0 && r < GRID_ROWS && c < GRID_COLS;
  endfunction

  function automatic bit cell_free(int r, int c);
    if (!on_grid(r, c)) return 1'b0;
    return !wall_map[r * GRID_COLS + c] && !on_path[r * GRID_COLS + c];
  endfunction

  function automatic void extend_path(int r, int c, inout maze_result_t res);
    on_path[r * GRID_COLS + c] = 1'b1;
    stk_row[path_depth] = 4'(r);
    stk_col[path_depth] = 4'(c);
    stk_dir[path_depth] = DIR_RIGHT;
    path_depth++;
    n_pushes++;
    res.ev = EV_PUSHED;
    res.row = 4'(r);
    res.col = 4'(c);
    if (r == exit_r && c == exit_c) begin
      res.at_exit = 1'b1;
      if (path_total < 65535) path_total++;
      found_flag = 1'b1;
      n_exits++;
    end
  endfunction

  function automatic void dfs_move(inout maze_result_t res);
    int top, r, c, nr, nc;
    logic [DIR_W-1:0] d;
    if (search_over) begin
      res.ev = EV_FINISHED;
      return;
    end
    if (path_depth == 0) begin
      if (!on_grid(start_r, start_c)) begin
        search_over = 1'b1;
        res.ev = EV_FINISHED;
      end else begin
        extend_path(start_r, start_c, res);
      end
      return;
    end
    top = path_depth - 1;
    r = stk_row[top];
    c = stk_col[top];
    // a full stack cannot grow, so the top cell goes back off
    if (path_depth < STACK_DEPTH) begin
      for (d = stk_dir[top]; d < DIR_NONE; d++) begin
        nr = r;
        nc = c;
        case (d)
          DIR_RIGHT: nc = c + 1;
          DIR_DOWN:  nr = r + 1;
          DIR_LEFT:  nc = c - 1;
          default:   nr = r - 1;
        endcase
        if (cell_free(nr, nc)) begin
          stk_dir[top] = d + 1'b1;
          extend_path(nr, nc, res);
          return;
        end
      end
    end
    stk_dir[top] = DIR_NONE;
    if (on_grid(r, c)) on_path[r * GRID_COLS + c] = 1'b0;
    path_depth--;
    if (path_depth == 0) search_over = 1'b1;
    n_pops++;
    res.ev = EV_POPPED;
    res.row = 4'(r);
    res.col = 4'(c);
  endfunction

  function automatic maze_result_t next_maze_result(logic [1:0] kind, logic [3:0] row,
                                                    logic [3:0] col, logic wall,
                                                    logic [7:0] idx);
    maze_result_t res;
    res = '0;
    case (kind)
      K_LOAD: begin
        if (on_grid(row, col)) wall_map[row * GRID_COLS + col] = wall;
        n_loads++;
        res.ev = EV_LOADED;
      end
      K_STEP: dfs_move(res);
      K_READ: begin
        n_reads++;
        res.ev = EV_READ;
        if (idx < path_depth && idx < STACK_DEPTH) begin
          res.row = stk_row[idx];
          res.col = stk_col[idx];
          res.entry_ok = 1'b1;
        end
      end
      K_RESTART: begin
        foreach (on_path[i]) on_path[i] = 1'b0;
        path_depth = 0;
        path_total = 0;
        found_flag = 1'b0;
        search_over = 1'b0;
        res.ev = EV_RESTARTED;
      end
    endcase
    res.depth = 9'(path_depth);
    res.count = 16'(path_total);
    res.found = found_flag;
    return res;
  endfunction

  function automatic string describe(maze_result_t r);
    return $sformatf("ev=%0d cell=(%0d,%0d) depth=%0d exit=%0b count=%0d found=%0b ok=%0b",
                     r.ev, r.row, r.col, r.depth, r.at_exit, r.count, r.found, r.entry_ok);
  endfunction

  // result checking: every strobe must match the oldest outstanding prediction
  always @(posedge clk) begin
    maze_result_t seen;
    maze_result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      seen = {out_event_res, out_cell_row, out_cell_col, out_depth, out_at_exit,
              out_path_count, out_found_any, out_entry_valid};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with nothing outstanding: %s", describe(seen));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high after a transaction; the next call either reloads it or drops it
  task automatic send_item(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                           logic wall, logic [7:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_kind <= kind;
    in_row <= row;
    in_col <= col;
    in_wall <= wall;
    in_entry_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(next_maze_result(kind, row, col, wall, idx));
    items_sent++;
  endtask

  // unused fields carry random values
  task automatic send_kind(logic [1:0] kind, logic [7:0] idx);
    send_item(kind, 4'($urandom), 4'($urandom), 1'($urandom), idx);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_START_ROW: start_r = val;
      CFG_START_COL: start_c = val;
      CFG_EXIT_ROW:  exit_r = val;
      CFG_EXIT_COL:  exit_c = val;
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_endpoints(logic [3:0] sr, logic [3:0] sc, logic [3:0] er, logic [3:0] ec);
    go_idle();
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_EXIT_ROW, er);
    write_reg(CFG_EXIT_COL, ec);
  endtask

  task automatic test_full_stack();
    gaps_on = 1'b1;
    set_endpoints('0, '0, 4'd7, 4'd7);
    // right, down, left, up from a corner spirals over the whole open grid
    repeat (STACK_DEPTH) send_kind(K_STEP, 8'($urandom));
    send_kind(K_READ, 8'(STACK_DEPTH - 1));
    send_kind(K_READ, 8'($urandom));
    repeat (4) send_kind(K_STEP, 8'($urandom));
    send_kind(K_RESTART, 8'($urandom));
  endtask

  task automatic test_corner_cases();
    logic [3:0] last_r;
    logic [3:0] last_c;
    last_r = 4'(GRID_ROWS - 1);
    last_c = 4'(GRID_COLS - 1);
    gaps_on = 1'b0;
    // start cell walled and boxed in by walls and the grid edge
    send_item(K_LOAD, last_r, last_c, 1'b1, 8'($urandom));
    send_item(K_LOAD, last_r - 4'd1, last_c, 1'b1, 8'($urandom));
    send_item(K_LOAD, last_r, last_c - 4'd1, 1'b1, 8'($urandom));
    send_item(K_LOAD, '0, '0, 1'b1, 8'($urandom));
    send_item(K_LOAD, '0, last_c, 1'b0, 8'($urandom));
    set_endpoints(last_r, last_c, last_r, last_c);
    send_kind(K_RESTART, 8'($urandom));
    send_kind(K_READ, 8'd0);
    send_kind(K_STEP, 8'($urandom));
    send_kind(K_READ, 8'd0);
    send_kind(K_READ, 8'd1);
    send_kind(K_READ, 8'hff);
    // pop of the start cell ends the search, later steps just report finished
    repeat (3) send_kind(K_STEP, 8'($urandom));
    set_endpoints('0, '0, '0, '0);
    send_kind(K_RESTART, 8'($urandom));
    repeat (2) send_kind(K_STEP, 8'($urandom));
    send_kind(K_RESTART, 8'($urandom));
  endtask

  task automatic test_random_searches();
    int r0, c0, h, w, rr, cc, moves, pick;
    logic [3:0] sr, sc, er, ec;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      // stray loads and reads between searches
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 1))
            send_item(K_LOAD, 4'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
          else
            send_kind(K_READ, 8'($urandom));
        end
      end
      // small walled-in box keeps the all-paths search short
      h = $urandom_range(2, 3);
      w = (h == 2) ? $urandom_range(2, 4) : $urandom_range(2, 3);
      r0 = $urandom_range(0, GRID_ROWS - h);
      c0 = $urandom_range(0, GRID_COLS - w);
      for (rr = r0 - 1; rr <= r0 + h; rr++) begin
        for (cc = c0 - 1; cc <= c0 + w; cc++) begin
          if (on_grid(rr, cc)) begin
            if (rr < r0 || rr >= r0 + h || cc < c0 || cc >= c0 + w)
              send_item(K_LOAD, 4'(rr), 4'(cc), 1'b1, 8'($urandom));
            else
              send_item(K_LOAD, 4'(rr), 4'(cc), $urandom_range(0, 9) < 3, 8'($urandom));
          end
        end
      end
      sr = 4'(r0 + $urandom_range(0, h - 1));
      sc = 4'(c0 + $urandom_range(0, w - 1));
      if ($urandom_range(0, 7) == 0) begin
        er = 4'($urandom);
        ec = 4'($urandom);
      end else begin
        er = 4'(r0 + $urandom_range(0, h - 1));
        ec = 4'(c0 + $urandom_range(0, w - 1));
      end
      set_endpoints(sr, sc, er, ec);
      send_kind(K_RESTART, 8'($urandom));
      moves = 0;
      while (!search_over && moves < SEARCH_BUDGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 74) begin
          send_kind(K_STEP, 8'($urandom));
        end else if (pick < 86) begin
          if ($urandom_range(0, 3) == 0) send_kind(K_READ, 8'($urandom));
          else send_kind(K_READ, 8'($urandom_range(0, path_depth)));
        end else if (pick < 92) begin
          send_item(K_LOAD, 4'(r0 + $urandom_range(0, h - 1)),
                    4'(c0 + $urandom_range(0, w - 1)), 1'($urandom), 8'($urandom));
        end else if (pick < 94) begin
          send_kind(K_RESTART, 8'($urandom));
        end else if (pick < 97) begin
          // move the goal while the search is under way
          go_idle();
          if ($urandom_range(0, 1))
            write_reg(CFG_EXIT_ROW, 4'(r0 + $urandom_range(0, h - 1)));
          else
            write_reg(CFG_EXIT_COL, 4'(c0 + $urandom_range(0, w - 1)));
        end else begin
          go_idle();
        end
        moves++;
      end
      repeat ($urandom_range(1, 3)) send_kind(K_STEP, 8'($urandom));
    end
  endtask

  initial begin
    foreach (wall_map[i]) wall_map[i] = 1'b0;
    foreach (on_path[i]) on_path[i] = 1'b0;
    path_depth = 0;
    path_total = 0;
    found_flag = 1'b0;
    search_over = 1'b0;
    start_r = 4'd1;
    start_c = 4'd1;
    exit_r = 4'd7;
    exit_c = 4'd7;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_stack();
    test_corner_cases();
    test_random_searches();

    go_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d items: %0d pushes, %0d pops, %0d exit arrivals, %0d reads, %0d loads",
             items_sent, n_pushes, n_pops, n_exits, n_reads, n_loads);
    $display("%0d register writes, %0d failures", n_cfg, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
